### hdl/varint_and_big_endian_serializer_macros.svh
// assertion macros for the varint and big-endian serializer
`ifndef VARINT_AND_BIG_ENDIAN_SERIALIZER_MACROS_SVH
`define VARINT_AND_BIG_ENDIAN_SERIALIZER_MACROS_SVH

// a property that must hold at every clock edge out of reset
`define VBE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// a condition in one cycle implies a consequence in the next
`define VBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/vbe_pkg.sv
// shared types, codes and helpers of the varint and big-endian serializer
`default_nettype none
package vbe_pkg;

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned GROUP_W  = 7;
	localparam int unsigned N_GROUPS = 10;

	localparam logic [2:0] CMD_BYTE  = 3'd0;
	localparam logic [2:0] CMD_INT32 = 3'd1;
	localparam logic [2:0] CMD_INT64 = 3'd2;
	localparam logic [2:0] CMD_VAR32 = 3'd3;
	localparam logic [2:0] CMD_VAR64 = 3'd4;

	// controls from the sequencer to the shift unit
	typedef struct packed {
		logic load;
		logic shift;
		logic big_endian;
	} shf_ctrl_t;

	function automatic logic cmd_known(input logic [2:0] c);
		logic ok;
		case (c)
			CMD_BYTE, CMD_INT32, CMD_INT64, CMD_VAR32, CMD_VAR64: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic cmd_is_varint(input logic [2:0] c);
		return (c == CMD_VAR32) || (c == CMD_VAR64);
	endfunction

	// byte count of the fixed-size modes
	function automatic logic [3:0] fixed_count(input logic [2:0] c);
		logic [3:0] n;
		case (c)
			CMD_INT32: n = 4'd4;
			CMD_INT64: n = 4'd8;
			default:   n = 4'd1;
		endcase
		return n;
	endfunction

	// big-endian modes are left aligned, varints right aligned
	function automatic logic [63:0] align_value(input logic [2:0] c, input logic [63:0] v);
		logic [63:0] r;
		case (c)
			CMD_BYTE:  r = {v[7:0], 56'd0};
			CMD_INT32: r = {v[31:0], 32'd0};
			CMD_VAR32: r = {32'd0, v[31:0]};
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/vbe_shifter.sv
// shared shift register that peels bytes or 7-bit groups off the value
`default_nettype none
module vbe_shifter
	import vbe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire shf_ctrl_t           ctrl,
	input  wire logic [2:0]          cmd,
	input  wire logic [VALUE_W-1:0]  value,
	output logic      [7:0]          raw_byte,
	output logic      [N_GROUPS-1:0] grp_nz
);

	logic [VALUE_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.load) begin
			data_q <= align_value(cmd, value);
		end else if (ctrl.shift) begin
			if (ctrl.big_endian) begin
				data_q <= {data_q[VALUE_W-9:0], 8'd0};
			end else begin
				data_q <= {7'd0, data_q[VALUE_W-1:GROUP_W]};
			end
		end
	end

	assign raw_byte = ctrl.big_endian ? data_q[VALUE_W-1:VALUE_W-8] : {1'b0, data_q[6:0]};

	// nonzero flag per 7-bit group, the top group holds only bit 63
	always_comb begin
		for (int i = 0; i < N_GROUPS - 1; i++) begin
			grp_nz[i] = |data_q[GROUP_W*i +: GROUP_W];
		end
		grp_nz[N_GROUPS-1] = data_q[VALUE_W-1];
	end

endmodule
`default_nettype wire

### hdl/vbe_seq.sv
// sequencer: takes an item, sizes it, then feeds the output register byte by byte
`default_nettype none
module vbe_seq
	import vbe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          cmd,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [7:0]          out_byte,
	output logic                     last,
	output logic      [3:0]          byte_count,
	input  wire logic [7:0]          raw_byte,
	input  wire logic [N_GROUPS-1:0] grp_nz,
	output shf_ctrl_t                ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic       varint_q;
	logic [3:0] count_q;
	logic [3:0] remain_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [3:0] bc_q;
	logic       out_free;
	logic [3:0] var_count;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign ctrl.load       = in_valid && (state_q == ST_IDLE) && cmd_known(cmd);
	assign ctrl.shift      = (state_q == ST_EMIT) && out_free;
	assign ctrl.big_endian = !varint_q;

	// highest nonzero group sets the varint length, at least one byte
	always_comb begin
		var_count = 4'd1;
		for (int i = 0; i < N_GROUPS; i++) begin
			if (grp_nz[i]) begin
				var_count = 4'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			varint_q    <= 1'b0;
			count_q     <= 4'd0;
			remain_q    <= 4'd0;
			out_valid_q <= 1'b0;
			byte_q      <= 8'd0;
			last_q      <= 1'b0;
			bc_q        <= 4'd0;
		end else begin
			// a free output register is refilled while emitting, else drained
			if (out_free) begin
				out_valid_q <= (state_q == ST_EMIT);
			end
			case (state_q)
				ST_IDLE: begin
					if (ctrl.load) begin
						varint_q <= cmd_is_varint(cmd);
						count_q  <= fixed_count(cmd);
						remain_q <= fixed_count(cmd);
						state_q  <= cmd_is_varint(cmd) ? ST_COUNT : ST_EMIT;
					end
				end
				ST_COUNT: begin
					count_q  <= var_count;
					remain_q <= var_count;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						byte_q      <= {raw_byte[7] | (varint_q && remain_q != 4'd1),
							raw_byte[6:0]};
						last_q      <= (remain_q == 4'd1);
						bc_q        <= count_q;
						remain_q    <= remain_q - 4'd1;
						if (remain_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign last       = last_q;
	assign byte_count = bc_q;

endmodule
`default_nettype wire

### hdl/varint_and_big_endian_serializer.sv
// top level of the varint and big-endian serializer
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, cmd, value   | item in
//  out     | out_valid, out_ready, out_byte,  | bytes of each item out
//          | last, byte_count                 |
//
// one item at a time: in_ready is high only while the sequencer is idle
// byte and big-endian items: accepted in idle, then n bytes emitted (n = 1, 4, 8)
// varint items: accepted in idle, sized in a counting state, then n bytes emitted (n = 1..10)
// bytes come off one 64-bit shift register, one byte per cycle at most
// a stalled out channel holds the byte register and freezes the shifter
// reset clears the sequencer and the output register, nothing else needed
`default_nettype none
`include "varint_and_big_endian_serializer_macros.svh"
module varint_and_big_endian_serializer
	import vbe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         cmd,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [7:0]         out_byte,
	output logic                    last,
	output logic      [3:0]         byte_count
);

	shf_ctrl_t           ctrl;
	logic [7:0]          raw_byte;
	logic [N_GROUPS-1:0] grp_nz;

	// shared shift unit holds the value being serialized
	vbe_shifter u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cmd      (cmd),
		.value    (value),
		.raw_byte (raw_byte),
		.grp_nz   (grp_nz)
	);

	// sequencer sizes the item and drives the output register
	vbe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last),
		.byte_count (byte_count),
		.raw_byte   (raw_byte),
		.grp_nz     (grp_nz),
		.ctrl       (ctrl)
	);

	// a known command starts work, so the block is busy next cycle
	`VBE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && cmd_known(cmd), !in_ready, "block still ready after taking an item")
	// every shown byte carries a count of one to ten
	`VBE_ASSERT_ALWAYS(a_count_range, !out_valid || (byte_count != 4'd0 && byte_count <= 4'd10), "byte count out of range")
	// a one-byte item is always flagged last
	`VBE_ASSERT_ALWAYS(a_single_last, !out_valid || byte_count != 4'd1 || last, "single byte item not flagged last")

endmodule
`default_nettype wire
